>>> design/wsd_pkg.sv
// Package for the WebSocket frame deframer.
// Holds parse phases, the queued result type and shared constants; no dependencies.
`default_nettype none

package wsd_pkg;

	localparam int unsigned LEN_W   = 20;
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QAW     = $clog2(QDEPTH);
	localparam int unsigned QCW     = $clog2(QDEPTH + 1);

	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(8192);
	localparam logic [7:0]       OPC_MASK        = 8'h0f;
	localparam logic [7:0]       MASK_BIT        = 8'h80;
	localparam logic [7:0]       LEN_CODE_MASK   = 8'h7f;
	localparam logic [6:0]       LEN_CODE_16     = 7'd126;
	localparam logic [6:0]       LEN_CODE_64     = 7'd127;
	localparam logic [2:0]       EXT16_LEFT      = 3'd1;
	localparam logic [2:0]       EXT64_LEFT      = 3'd7;
	localparam logic [2:0]       KEY_LEFT        = 3'd3;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_MASKKEY,
		PH_PAYLOAD,
		PH_HALTED
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic [3:0] opcode;
		logic       frame_end;
		logic       empty_frame;
		logic       too_large;
	} op_t;

endpackage

`default_nettype wire

>>> design/wsd_front.sv
// Header parser of the WebSocket frame deframer: classifies each input byte.
// Pushes one result descriptor per result into the queue. Uses wsd_pkg.
`default_nettype none

module wsd_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [7:0]               rx_byte,
	input  wire logic                     q_full,
	input  wire logic [wsd_pkg::LEN_W-1:0] max_len,
	output wsd_pkg::op_t                  push_op,
	output logic                          push
);

	wsd_pkg::phase_t          ph_q, ph_d;
	logic [3:0]               opc_q, opc_d;
	logic                     mask_q, mask_d;
	logic [2:0]               hb_q, hb_d;
	logic [wsd_pkg::LEN_W-1:0] len_q, len_d;
	logic                     hi_q, hi_d;
	logic [31:0]              key_q, key_d;
	logic [wsd_pkg::LEN_W-1:0] left_q, left_d;
	logic [1:0]               idx_q, idx_d;

	logic                     acc;
	logic                     ld_go;
	logic [wsd_pkg::LEN_W-1:0] ld_len;
	logic                     ld_hi;
	logic                     bp_go;
	logic [wsd_pkg::LEN_W-1:0] bp_len;
	logic [6:0]               code;
	logic [7:0]               kb;

	assign acc  = in_valid & ~q_full;
	assign code = 7'(rx_byte & wsd_pkg::LEN_CODE_MASK);

	always_comb begin
		case (idx_q)
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
		if (!mask_q) begin
			kb = 8'h00;
		end
	end

	always_comb begin
		ph_d    = ph_q;
		opc_d   = opc_q;
		mask_d  = mask_q;
		hb_d    = hb_q;
		len_d   = len_q;
		hi_d    = hi_q;
		key_d   = key_q;
		left_d  = left_q;
		idx_d   = idx_q;
		push    = 1'b0;
		push_op = '{data: rx_byte, key: kb, opcode: opc_q, frame_end: 1'b0,
			empty_frame: 1'b0, too_large: 1'b0};
		ld_go   = 1'b0;
		ld_len  = len_q;
		ld_hi   = hi_q;
		bp_go   = 1'b0;
		bp_len  = len_q;

		if (acc) begin
			unique case (ph_q)
				wsd_pkg::PH_HDR0: begin
					opc_d = 4'(rx_byte & wsd_pkg::OPC_MASK);
					ph_d  = wsd_pkg::PH_HDR1;
				end
				wsd_pkg::PH_HDR1: begin
					mask_d = |(rx_byte & wsd_pkg::MASK_BIT);
					if (code == wsd_pkg::LEN_CODE_16 || code == wsd_pkg::LEN_CODE_64) begin
						len_d = '0;
						hi_d  = 1'b0;
						hb_d  = (code == wsd_pkg::LEN_CODE_16) ? wsd_pkg::EXT16_LEFT
							: wsd_pkg::EXT64_LEFT;
						ph_d  = wsd_pkg::PH_EXTLEN;
					end else begin
						ld_go  = 1'b1;
						ld_len = wsd_pkg::LEN_W'(code);
						ld_hi  = 1'b0;
					end
				end
				wsd_pkg::PH_EXTLEN: begin
					ld_len = {len_q[wsd_pkg::LEN_W-9:0], rx_byte};
					ld_hi  = hi_q | (|len_q[wsd_pkg::LEN_W-1:wsd_pkg::LEN_W-8]);
					len_d  = ld_len;
					hi_d   = ld_hi;
					if (hb_q == 3'd0) begin
						ld_go = 1'b1;
					end else begin
						hb_d = hb_q - 3'd1;
					end
				end
				wsd_pkg::PH_MASKKEY: begin
					key_d = {key_q[23:0], rx_byte};
					if (hb_q == 3'd0) begin
						bp_go = 1'b1;
					end else begin
						hb_d = hb_q - 3'd1;
					end
				end
				wsd_pkg::PH_PAYLOAD: begin
					idx_d  = idx_q + 2'd1;
					left_d = left_q - wsd_pkg::LEN_W'(1);
					push   = 1'b1;
					if (left_q == wsd_pkg::LEN_W'(1)) begin
						push_op.frame_end = 1'b1;
						ph_d = wsd_pkg::PH_HDR0;
					end
				end
				wsd_pkg::PH_HALTED: begin
				end
				default: begin
				end
			endcase
		end

		// length complete: size check, then key, payload or empty-frame result
		if (ld_go) begin
			len_d = ld_len;
			hi_d  = ld_hi;
			if (ld_hi || (ld_len > max_len)) begin
				push              = 1'b1;
				push_op.data      = 8'h00;
				push_op.key       = 8'h00;
				push_op.too_large = 1'b1;
				ph_d              = wsd_pkg::PH_HALTED;
			end else begin
				key_d = '0;
				if (mask_d) begin
					hb_d = wsd_pkg::KEY_LEFT;
					ph_d = wsd_pkg::PH_MASKKEY;
				end else begin
					bp_go  = 1'b1;
					bp_len = ld_len;
				end
			end
		end

		if (bp_go) begin
			if (bp_len == '0) begin
				push                = 1'b1;
				push_op.data        = 8'h00;
				push_op.key         = 8'h00;
				push_op.frame_end   = 1'b1;
				push_op.empty_frame = 1'b1;
				ph_d                = wsd_pkg::PH_HDR0;
			end else begin
				left_d = bp_len;
				idx_d  = 2'd0;
				ph_d   = wsd_pkg::PH_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= wsd_pkg::PH_HDR0;
			opc_q  <= '0;
			mask_q <= 1'b0;
			hb_q   <= '0;
			len_q  <= '0;
			hi_q   <= 1'b0;
			key_q  <= '0;
			left_q <= '0;
			idx_q  <= '0;
		end else begin
			ph_q   <= ph_d;
			opc_q  <= opc_d;
			mask_q <= mask_d;
			hb_q   <= hb_d;
			len_q  <= len_d;
			hi_q   <= hi_d;
			key_q  <= key_d;
			left_q <= left_d;
			idx_q  <= idx_d;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == wsd_pkg::PH_HALTED |=> ph_q == wsd_pkg::PH_HALTED)
		else $error("parser left halted phase");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == wsd_pkg::PH_PAYLOAD |-> left_q != '0)
		else $error("payload phase with zero bytes left");

endmodule

`default_nettype wire

>>> design/wsd_queue.sv
// Small result queue between the parser and the output stage.
// Register array with one read port at the head. Uses wsd_pkg.
`default_nettype none

module wsd_queue (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire wsd_pkg::op_t push_op,
	input  wire logic  pop,
	output wsd_pkg::op_t head_op,
	output logic       full,
	output logic       empty
);

	wsd_pkg::op_t            mem_q [wsd_pkg::QDEPTH];
	logic [wsd_pkg::QAW-1:0] wr_ptr_q;
	logic [wsd_pkg::QAW-1:0] rd_ptr_q;
	logic [wsd_pkg::QCW-1:0] cnt_q;

	assign full    = (cnt_q == wsd_pkg::QCW'(wsd_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign head_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + wsd_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + wsd_pkg::QAW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + wsd_pkg::QCW'(1);
				2'b01:   cnt_q <= cnt_q - wsd_pkg::QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("push into full queue");

endmodule

`default_nettype wire

>>> design/wsd_back.sv
// Output stage of the WebSocket frame deframer: unmasks queued items.
// Drives the registered result channel. Uses wsd_pkg.
`default_nettype none

module wsd_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire wsd_pkg::op_t head_op,
	input  wire logic       q_empty,
	output logic            pop,
	input  wire logic       out_stall,
	output logic            out_valid,
	output logic [7:0]      payload_byte,
	output logic [3:0]      frame_opcode,
	output logic            frame_end,
	output logic            empty_frame,
	output logic            too_large
);

	logic       vld_q;
	logic [7:0] byte_q;
	logic [3:0] opc_q;
	logic       end_q;
	logic       empty_q;
	logic       big_q;

	assign pop = ~q_empty & (~vld_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || !out_stall) begin
			vld_q <= ~q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q  <= head_op.data ^ head_op.key;
			opc_q   <= head_op.opcode;
			end_q   <= head_op.frame_end;
			empty_q <= head_op.empty_frame;
			big_q   <= head_op.too_large;
		end
	end

	assign out_valid    = vld_q;
	assign payload_byte = byte_q;
	assign frame_opcode = opc_q;
	assign frame_end    = end_q;
	assign empty_frame  = empty_q;
	assign too_large    = big_q;

	a_flag_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && (empty_q || big_q) |-> byte_q == 8'h00)
		else $error("nonzero byte on empty or error result");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && empty_q |-> end_q && !big_q)
		else $error("empty frame result not marked as end");

endmodule

`default_nettype wire

>>> design/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer.
// Holds the size limit register and joins wsd_front, wsd_queue and wsd_back; uses wsd_pkg.
`default_nettype none

// Takes one stream byte per cycle and parses WebSocket frames: opcode, mask bit,
// 7/16/64-bit length and optional mask key. Every payload byte comes out unmasked
// with its opcode, the last one flagged by frame_end; a zero-length frame gives one
// empty_frame item, and a length above the size limit gives one too_large item
// after which all input is swallowed until reset. A byte is accepted every cycle
// as long as the four-entry queue between the header parser and the output
// register has room, so sustained rate is one byte per cycle when the sink keeps
// up; each result is stored in the queue and then in the output register. The limit
// register resets to 8192 and is written through cfg_wr_en/cfg_wr_data.
module websocket_frame_deframer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [wsd_pkg::LEN_W-1:0] cfg_wr_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [7:0]                rx_byte,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [7:0]                     payload_byte,
	output logic [3:0]                     frame_opcode,
	output logic                           frame_end,
	output logic                           empty_frame,
	output logic                           too_large
);

	logic [wsd_pkg::LEN_W-1:0] max_len_q;
	wsd_pkg::op_t              push_op;
	wsd_pkg::op_t              head_op;
	logic                      push;
	logic                      pop;
	logic                      q_full;
	logic                      q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= wsd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	assign in_stall = q_full;

	wsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.max_len  (max_len_q),
		.push_op  (push_op),
		.push     (push)
	);

	wsd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	wsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_op      (head_op),
		.q_empty      (q_empty),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.payload_byte (payload_byte),
		.frame_opcode (frame_opcode),
		.frame_end    (frame_end),
		.empty_frame  (empty_frame),
		.too_large    (too_large)
	);

endmodule

`default_nettype wire
